>>> rtl/mwrd_pkg.sv
// shared types, codes and helpers of the motion window rms detector
package mwrd_pkg;

  localparam int WINDOW_SAMPLES_DEF = 32;

  localparam int OP_W      = 2;
  localparam int ACCEL_W   = 16;
  localparam int RMS_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int ROOT_ARG_W = 32;

  localparam logic [OP_W-1:0] OP_SAMPLE    = 2'd0;
  localparam logic [OP_W-1:0] OP_CLR_START = 2'd1;
  localparam logic [OP_W-1:0] OP_CLR_STOP  = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP       = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_MOTION_THR = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATT_THR    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HP_ALPHA   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_LEN   = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]           op;
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
  } in_item_t;

  typedef struct packed {
    logic [RMS_W-1:0] motion_rms_mg;
    logic             motion_started;
    logic             motion_stopped;
    logic             attitude_changed;
  } out_item_t;

  typedef struct packed {
    logic signed [ACCEL_W-1:0] x;
    logic signed [ACCEL_W-1:0] y;
    logic signed [ACCEL_W-1:0] z;
  } ring_entry_t;

  function automatic int imax(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> rtl/motion_window_rms_detector_top.sv
// motion window rms detector: sample window, high-pass attitude path and confirmation counters
//
// Input channel in_valid/in_ready/in_data carries one transaction per sample or command;
// each accepted transaction yields exactly one result on out_valid/out_ready/out_data.
// Op 0 is an accelerometer sample, op 1 clears the start counters, op 2 clears the stop
// counter, op 3 only reports. A sample runs through a sequencer that uses one shared
// multiplier for both high-pass filters, the window squares and the variance terms, then
// a shared divide and square root unit (32 plus 16 steps). A sample runs the whole state
// sequence, root unit included, before out_valid; a command goes straight to done. in_ready is
// high only while the sequencer is idle, so no new sample is taken until the last is done.
// The result sits in an output register; the next transaction is accepted while it waits,
// and the sequencer holds its finished result until the output register is free.
// The window is a memory of WINDOW_SAMPLES entries read through a registered port; a fill
// count tracks which entries hold samples, so no clearing pass is needed after reset.
// Configuration writes on cfg_we/cfg_addr/cfg_wdata take effect at once and are meant
// for idle periods only. Synchronous active-low reset restores register defaults and
// clears all window sums, filter history and counters.
module motion_window_rms_detector_top #(
  parameter int WINDOW_SAMPLES = mwrd_pkg::WINDOW_SAMPLES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  mwrd_pkg::in_item_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output mwrd_pkg::out_item_t              out_data,
  input  logic                             cfg_we,
  input  logic [mwrd_pkg::CFG_IDX_W-1:0]   cfg_addr,
  input  logic [mwrd_pkg::CFG_W-1:0]       cfg_wdata
);
  import mwrd_pkg::*;

  localparam int W     = WINDOW_SAMPLES;
  localparam int IDX_W = (W > 1) ? $clog2(W) : 1;
  localparam int CNT_W = $clog2(W + 1);
  localparam int SUM_W = ACCEL_W + CNT_W;
  localparam int SQ_W  = 2 * ACCEL_W + CNT_W;
  localparam int NUM_W = SQ_W + CNT_W;
  localparam int DEN_W = 2 * CNT_W;
  localparam int HPD_W = 34;
  localparam int MA_W  = imax(imax(HPD_W, SQ_W + 1), SUM_W);
  localparam int MB_W  = imax(imax(17, SUM_W), CNT_W + 1);
  localparam int P_W   = MA_W + MB_W;
  localparam logic signed [P_W-1:0] Q_MAX = P_W'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [P_W-1:0] Q_MIN = P_W'(-64'sh0000_0000_8000_0000);

  typedef enum logic [17:0] {
    S_IDLE  = 18'b000000000000000001,
    S_HPX   = 18'b000000000000000010,
    S_HPY   = 18'b000000000000000100,
    S_OX    = 18'b000000000000001000,
    S_OY    = 18'b000000000000010000,
    S_OZ    = 18'b000000000000100000,
    S_NX    = 18'b000000000001000000,
    S_NY    = 18'b000000000010000000,
    S_NZ    = 18'b000000000100000000,
    S_NS    = 18'b000000001000000000,
    S_NM    = 18'b000000010000000000,
    S_AX    = 18'b000000100000000000,
    S_AY    = 18'b000001000000000000,
    S_AZ    = 18'b000010000000000000,
    S_SUB   = 18'b000100000000000000,
    S_CLAMP = 18'b001000000000000000,
    S_ROOT  = 18'b010000000000000000,
    S_DONE  = 18'b100000000000000000
  } state_t;

  state_t state_r, state_nxt;

  // configuration
  logic [15:0] motion_thr_r;
  logic [14:0] att_thr_r;
  logic [15:0] alpha_r;
  logic [15:0] start_len_r;
  logic [15:0] stop_len_r;

  // item and window state
  in_item_t                 in_r;
  ring_entry_t              ring_mem [W];
  ring_entry_t              rd_q;
  logic [IDX_W-1:0]         head_r;
  logic [CNT_W-1:0]         fill_r;
  logic signed [SUM_W-1:0]  sum_r [3];
  logic [SQ_W-1:0]          sq_r;
  logic signed [15:0]       prev_in_r [2];
  logic signed [31:0]       prev_out_r [2];
  logic                     primed_r;
  logic signed [31:0]       hx_r;
  logic [15:0]              above_r;
  logic [15:0]              below_r;
  logic [15:0]              att_cnt_r;
  logic [RMS_W-1:0]         rms_r;
  logic [DEN_W-1:0]         nn_r;
  logic [NUM_W-1:0]         num_r;
  logic [NUM_W-1:0]         sub_r;
  out_item_t                out_r;
  logic                     out_valid_r;

  // shared multiplier
  logic signed [MA_W-1:0]   mul_a;
  logic signed [MB_W-1:0]   mul_b;
  logic signed [P_W-1:0]    prod_r;

  logic                     full;
  logic                     hp_y_sel;
  logic signed [15:0]       hp_in;
  logic signed [15:0]       hp_pin;
  logic signed [31:0]       hp_pout;
  logic signed [16:0]       hp_diff;
  logic signed [HPD_W-1:0]  hp_d;
  logic signed [P_W-1:0]    hp_t;
  logic signed [P_W-1:0]    hp_q;
  logic signed [31:0]       hp_sat;
  logic signed [31:0]       hy_now;
  logic [32:0]              hx_abs;
  logic [32:0]              hy_abs;
  logic [32:0]              att_lim;
  logic                     att_hit;
  logic signed [15:0]       old_s [3];
  logic signed [15:0]       new_s [3];
  logic [NUM_W-1:0]         root_num;
  logic                     root_start;
  logic                     root_busy;
  logic                     root_done;
  logic [RMS_W-1:0]         root_val;
  logic                     accept;
  logic                     load_out;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign load_out = (state_r == S_DONE) && (!out_valid_r || out_ready);
  assign full     = (fill_r == CNT_W'(W));

  assign old_s[0] = rd_q.x;
  assign old_s[1] = rd_q.y;
  assign old_s[2] = rd_q.z;
  assign new_s[0] = in_r.accel_x;
  assign new_s[1] = in_r.accel_y;
  assign new_s[2] = in_r.accel_z;

  // high-pass datapath
  assign hp_y_sel = (state_r == S_HPY);
  assign hp_in    = hp_y_sel ? in_r.accel_y : in_r.accel_x;
  assign hp_pin   = hp_y_sel ? prev_in_r[1] : prev_in_r[0];
  assign hp_pout  = hp_y_sel ? prev_out_r[1] : prev_out_r[0];
  assign hp_diff  = 17'(hp_in) - 17'(hp_pin);
  assign hp_d     = HPD_W'(hp_pout) + (HPD_W'(hp_diff) <<< 8);
  assign hp_t     = prod_r + P_W'(32768);
  assign hp_q     = hp_t >>> 16;

  always_comb begin
    if (hp_q > Q_MAX) begin
      hp_sat = 32'sh7FFF_FFFF;
    end else if (hp_q < Q_MIN) begin
      hp_sat = -32'sh8000_0000;
    end else begin
      hp_sat = hp_q[31:0];
    end
  end

  assign hy_now  = primed_r ? hp_sat : 32'sd0;
  assign hx_abs  = hx_r[31] ? (33'd0 - {1'b1, hx_r}) : {1'b0, hx_r};
  assign hy_abs  = hy_now[31] ? (33'd0 - {1'b1, hy_now}) : {1'b0, hy_now};
  assign att_lim = {10'd0, att_thr_r, 8'd0};
  assign att_hit = (hx_abs >= att_lim) || (hy_abs >= att_lim);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_HPX, S_HPY: begin
        mul_a = MA_W'(hp_d);
        mul_b = MB_W'($signed({1'b0, alpha_r}));
      end
      S_OX: begin
        mul_a = MA_W'(old_s[0]);
        mul_b = MB_W'(old_s[0]);
      end
      S_OY: begin
        mul_a = MA_W'(old_s[1]);
        mul_b = MB_W'(old_s[1]);
      end
      S_OZ: begin
        mul_a = MA_W'(old_s[2]);
        mul_b = MB_W'(old_s[2]);
      end
      S_NX: begin
        mul_a = MA_W'(new_s[0]);
        mul_b = MB_W'(new_s[0]);
      end
      S_NY: begin
        mul_a = MA_W'(new_s[1]);
        mul_b = MB_W'(new_s[1]);
      end
      S_NZ: begin
        mul_a = MA_W'(new_s[2]);
        mul_b = MB_W'(new_s[2]);
      end
      S_NS: begin
        mul_a = MA_W'($signed({1'b0, fill_r}));
        mul_b = MB_W'($signed({1'b0, fill_r}));
      end
      S_NM: begin
        mul_a = MA_W'($signed({1'b0, sq_r}));
        mul_b = MB_W'($signed({1'b0, fill_r}));
      end
      S_AX: begin
        mul_a = MA_W'(sum_r[0]);
        mul_b = MB_W'(sum_r[0]);
      end
      S_AY: begin
        mul_a = MA_W'(sum_r[1]);
        mul_b = MB_W'(sum_r[1]);
      end
      S_AZ: begin
        mul_a = MA_W'(sum_r[2]);
        mul_b = MB_W'(sum_r[2]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  // window memory, read port follows the head pointer
  always_ff @(posedge clk) begin
    if (state_r == S_NX) begin
      ring_mem[head_r] <= '{x: in_r.accel_x, y: in_r.accel_y, z: in_r.accel_z};
    end
    rd_q <= ring_mem[head_r];
  end

  assign root_num   = (num_r > sub_r) ? (num_r - sub_r) : '0;
  assign root_start = (state_r == S_CLAMP);

  mwrd_root #(
    .CNT_W (CNT_W)
  ) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .num   (root_num),
    .den   (nn_r),
    .busy  (root_busy),
    .done  (root_done),
    .root  (root_val)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = (in_data.op == OP_SAMPLE) ? S_HPX : S_DONE;
        end
      end
      S_HPX:   state_nxt = S_HPY;
      S_HPY:   state_nxt = S_OX;
      S_OX:    state_nxt = S_OY;
      S_OY:    state_nxt = S_OZ;
      S_OZ:    state_nxt = S_NX;
      S_NX:    state_nxt = S_NY;
      S_NY:    state_nxt = S_NZ;
      S_NZ:    state_nxt = S_NS;
      S_NS:    state_nxt = S_NM;
      S_NM:    state_nxt = S_AX;
      S_AX:    state_nxt = S_AY;
      S_AY:    state_nxt = S_AZ;
      S_AZ:    state_nxt = S_SUB;
      S_SUB:   state_nxt = S_CLAMP;
      S_CLAMP: state_nxt = S_ROOT;
      S_ROOT: begin
        if (root_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and window state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      motion_thr_r  <= 16'd50;
      att_thr_r     <= 15'd100;
      alpha_r       <= 16'd62000;
      start_len_r   <= 16'd20;
      stop_len_r    <= 16'd1200;
      head_r        <= '0;
      fill_r        <= '0;
      sum_r[0]      <= '0;
      sum_r[1]      <= '0;
      sum_r[2]      <= '0;
      sq_r          <= '0;
      prev_in_r[0]  <= '0;
      prev_in_r[1]  <= '0;
      prev_out_r[0] <= '0;
      prev_out_r[1] <= '0;
      primed_r      <= 1'b0;
      above_r       <= '0;
      below_r       <= '0;
      att_cnt_r     <= '0;
      rms_r         <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_addr)
          REG_MOTION_THR: motion_thr_r <= cfg_wdata;
          REG_ATT_THR:    att_thr_r    <= cfg_wdata[14:0];
          REG_HP_ALPHA:   alpha_r      <= cfg_wdata;
          REG_START_LEN:  start_len_r  <= cfg_wdata;
          REG_STOP_LEN:   stop_len_r   <= cfg_wdata;
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_data.op == OP_CLR_START) begin
              above_r   <= '0;
              att_cnt_r <= '0;
            end else if (in_data.op == OP_CLR_STOP) begin
              below_r <= '0;
            end
          end
        end
        S_HPY: begin
          prev_in_r[0]  <= in_r.accel_x;
          prev_out_r[0] <= primed_r ? hp_sat : 32'sd0;
        end
        S_OX: begin
          prev_in_r[1]  <= in_r.accel_y;
          prev_out_r[1] <= hy_now;
          primed_r      <= 1'b1;
          if (att_hit) begin
            if (att_cnt_r < start_len_r) begin
              att_cnt_r <= att_cnt_r + 1'b1;
            end
          end else begin
            att_cnt_r <= '0;
          end
        end
        S_OY, S_OZ: begin
          if (full) begin
            sq_r <= sq_r - prod_r[SQ_W-1:0];
          end
        end
        S_NX: begin
          if (full) begin
            sq_r <= sq_r - prod_r[SQ_W-1:0];
          end else begin
            fill_r <= fill_r + 1'b1;
          end
          for (int k = 0; k < 3; k++) begin
            sum_r[k] <= sum_r[k] - (full ? SUM_W'(old_s[k]) : SUM_W'(0)) + SUM_W'(new_s[k]);
          end
          head_r <= (head_r == IDX_W'(W - 1)) ? '0 : head_r + 1'b1;
        end
        S_NY, S_NZ, S_NS: begin
          sq_r <= sq_r + prod_r[SQ_W-1:0];
        end
        S_ROOT: begin
          if (root_done) begin
            rms_r <= root_val;
            if (root_val >= motion_thr_r) begin
              if (above_r < start_len_r) begin
                above_r <= above_r + 1'b1;
              end
              below_r <= '0;
            end else begin
              if (below_r < stop_len_r) begin
                below_r <= below_r + 1'b1;
              end
              above_r <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      in_r <= in_data;
    end
    if (state_r == S_HPY) begin
      hx_r <= primed_r ? hp_sat : 32'sd0;
    end
    if (state_r == S_NM) begin
      nn_r <= prod_r[DEN_W-1:0];
    end
    if (state_r == S_AX) begin
      num_r <= prod_r[NUM_W-1:0];
    end
    if (state_r == S_AY) begin
      sub_r <= prod_r[NUM_W-1:0];
    end
    if (state_r == S_AZ || state_r == S_SUB) begin
      sub_r <= sub_r + prod_r[NUM_W-1:0];
    end
    if (load_out) begin
      out_r.motion_rms_mg    <= rms_r;
      out_r.motion_started   <= (above_r >= start_len_r);
      out_r.motion_stopped   <= (below_r >= stop_len_r);
      out_r.attitude_changed <= (att_cnt_r >= start_len_r);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result shown without finishing a transaction");
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("ready right after acceptance");
  a_head_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    !full |-> (head_r == fill_r[IDX_W-1:0]))
    else $error("head pointer out of step with fill count");
  a_root_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    root_start |-> !root_busy)
    else $error("root unit started while busy");

endmodule

>>> rtl/mwrd_root.sv
// sequential divide then integer square root on one shared compare-subtract unit
module mwrd_root #(
  parameter int CNT_W = 6
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    start,
  input  logic [mwrd_pkg::ROOT_ARG_W+2*CNT_W-1:0] num,
  input  logic [2*CNT_W-1:0]                      den,
  output logic                                    busy,
  output logic                                    done,
  output logic [mwrd_pkg::RMS_W-1:0]              root
);
  import mwrd_pkg::*;

  localparam int NUM_W  = ROOT_ARG_W + 2 * CNT_W;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int SREM_W = RMS_W + 2;
  localparam int SR2_W  = SREM_W + 2;
  localparam int CS_W   = imax(DEN_W + 1, SR2_W);
  localparam int DIV_STEPS  = ROOT_ARG_W;
  localparam int SQRT_STEPS = ROOT_ARG_W / 2;
  localparam int STEP_W     = $clog2(DIV_STEPS);

  typedef enum logic [2:0] {
    P_IDLE = 3'b001,
    P_DIV  = 3'b010,
    P_SQRT = 3'b100
  } phase_t;

  phase_t                  phase_r;
  logic [STEP_W-1:0]       step_r;
  logic [DEN_W-1:0]        drem_r;
  logic [ROOT_ARG_W-1:0]   dq_r;
  logic [DEN_W-1:0]        den_r;
  logic [ROOT_ARG_W-1:0]   sval_r;
  logic [SREM_W-1:0]       srem_r;
  logic [RMS_W-1:0]        sroot_r;
  logic                    done_r;

  logic [DEN_W:0]          div_sh;
  logic [SR2_W-1:0]        sq_r2;
  logic [SR2_W-1:0]        sq_trial;
  logic [CS_W-1:0]         cs_a;
  logic [CS_W-1:0]         cs_b;
  logic [CS_W:0]           cs_diff;
  logic                    cs_ge;
  logic [ROOT_ARG_W-1:0]   quot_nxt;

  assign div_sh   = {drem_r, dq_r[ROOT_ARG_W-1]};
  assign sq_r2    = {srem_r, sval_r[ROOT_ARG_W-1 -: 2]};
  assign sq_trial = SR2_W'({sroot_r, 2'b01});

  // shared compare-subtract
  always_comb begin
    if (phase_r == P_SQRT) begin
      cs_a = CS_W'(sq_r2);
      cs_b = CS_W'(sq_trial);
    end else begin
      cs_a = CS_W'(div_sh);
      cs_b = CS_W'(den_r);
    end
  end

  assign cs_diff  = {1'b0, cs_a} - {1'b0, cs_b};
  assign cs_ge    = !cs_diff[CS_W];
  assign quot_nxt = {dq_r[ROOT_ARG_W-2:0], cs_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_IDLE;
      step_r  <= '0;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      unique case (phase_r)
        P_IDLE: begin
          if (start) begin
            phase_r <= P_DIV;
            step_r  <= '0;
          end
        end
        P_DIV: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(DIV_STEPS - 1)) begin
            phase_r <= P_SQRT;
            step_r  <= '0;
          end
        end
        P_SQRT: begin
          step_r <= step_r + 1'b1;
          if (step_r == STEP_W'(SQRT_STEPS - 1)) begin
            phase_r <= P_IDLE;
            done_r  <= 1'b1;
          end
        end
        default: phase_r <= P_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (phase_r == P_IDLE && start) begin
      drem_r <= num[NUM_W-1:ROOT_ARG_W];
      dq_r   <= num[ROOT_ARG_W-1:0];
      den_r  <= den;
    end else if (phase_r == P_DIV) begin
      drem_r <= cs_ge ? cs_diff[DEN_W-1:0] : div_sh[DEN_W-1:0];
      dq_r   <= quot_nxt;
      if (step_r == STEP_W'(DIV_STEPS - 1)) begin
        sval_r  <= quot_nxt;
        srem_r  <= '0;
        sroot_r <= '0;
      end
    end else if (phase_r == P_SQRT) begin
      sval_r  <= {sval_r[ROOT_ARG_W-3:0], 2'b00};
      srem_r  <= cs_ge ? cs_diff[SREM_W-1:0] : sq_r2[SREM_W-1:0];
      sroot_r <= {sroot_r[RMS_W-2:0], cs_ge};
    end
  end

  assign busy = (phase_r != P_IDLE);
  assign done = done_r;
  assign root = sroot_r;

  a_done_after_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> $past(phase_r == P_SQRT))
    else $error("root done without square root phase");
  a_start_begins_div: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (phase_r == P_DIV && step_r == '0))
    else $error("start did not begin division");
  a_div_to_sqrt: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == P_DIV && step_r == STEP_W'(DIV_STEPS - 1)) |=> (phase_r == P_SQRT))
    else $error("division did not hand over to square root");

endmodule
